FILE: rtl/imu_afp_pkg.sv
// ----------------------------------------------------------------------------
// imu_afp_pkg: shared types and constants of the attitude frame parser
// Frame marker, angle store size and the result word carried to the output.
// ----------------------------------------------------------------------------
`default_nettype none

package imu_afp_pkg;

  // Every frame opens with this byte twice.
  localparam logic [7:0] SYNC_BYTE = 8'h55;

  // Number of payload bytes that are kept for the angle codes.
  localparam int unsigned ANGLE_BYTES = 6;
  localparam int unsigned ANGLE_IDX_W = $clog2(ANGLE_BYTES);

  // Width of the length and position counters.
  localparam int unsigned LEN_W = 6;

  typedef logic [7:0] byte_t;

  typedef struct packed {
    logic signed [15:0] roll;
    logic signed [15:0] pitch;
    logic signed [15:0] yaw;
  } angles_t;

endpackage

`default_nettype wire

FILE: rtl/imu_attitude_frame_parser.sv
// ----------------------------------------------------------------------------
// imu_attitude_frame_parser: sync/length/checksum frame parser for attitude
// Finds 0x55 0x55 framed messages in a byte stream and emits angle codes.
// ----------------------------------------------------------------------------
// The block takes one received byte per input word and hunts for frames laid
// out as two 0x55 sync bytes, a message id, a length of at most MAX_PAYLOAD,
// the payload and a checksum, which is the 8-bit wrapping sum of every earlier
// frame byte including the sync bytes. The first six payload bytes are kept;
// a short payload leaves older bytes (or zero after reset) in place. When the
// checksum matches and the id equals attitude_message_id (written through
// cfg_write_en / cfg_write_data, reset value 1), one output word carries the
// signed roll, pitch and yaw codes taken little endian from payload bytes 1:0,
// 3:2 and 5:4; degrees equal code * 180 / 32768. Each input word is taken into
// an input register and handled by the parser step once that register may
// advance; the result is loaded into the output register when the parser step
// handles its checksum byte. The block sustains one byte per cycle, and it
// only waits when it must deliver a result while the output register still
// holds an untaken one. Configuration should be written while no frame is in
// flight.
// ----------------------------------------------------------------------------
`default_nettype none

module imu_attitude_frame_parser import imu_afp_pkg::*; #(
  parameter int unsigned MAX_PAYLOAD = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,

  input  wire logic        cfg_write_en,
  input  wire logic [7:0]  cfg_write_data,

  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  rx_byte,

  output logic             out_valid,
  input  wire logic        out_stall,
  output logic signed [15:0] roll_code,
  output logic signed [15:0] pitch_code,
  output logic signed [15:0] yaw_code
);

  // Id of the frames that carry attitude angles.
  byte_t attitude_message_id;

  // Input register: one byte waiting for the parser step.
  logic  in_full;
  byte_t in_byte;

  logic    in_accept;
  logic    advance;
  logic    hit;
  angles_t angles;
  angles_t result;

  always_ff @(posedge clk) begin
    if (rst) begin
      attitude_message_id <= 8'd1;
    end else if (cfg_write_en) begin
      attitude_message_id <= cfg_write_data;
    end
  end

  // The held byte moves through the parser unless it completes a good frame
  // while the output register is still occupied and stalled.
  assign advance   = in_full && (!hit || !out_valid || !out_stall);
  assign in_stall  = in_full && !advance;
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_accept) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      in_byte <= rx_byte;
    end
  end

  imu_afp_parser #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_parser (
    .clk         (clk),
    .rst         (rst),
    .step        (advance),
    .rx_byte     (in_byte),
    .attitude_id (attitude_message_id),
    .hit         (hit),
    .angles      (angles)
  );

  imu_afp_result_reg u_result (
    .clk       (clk),
    .rst       (rst),
    .load      (advance && hit),
    .load_data (angles),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .data      (result)
  );

  assign roll_code  = result.roll;
  assign pitch_code = result.pitch;
  assign yaw_code   = result.yaw;

  // A good frame that the parser consumes always shows up at the output.
  a_hit_loads: assert property (@(posedge clk) disable iff (rst)
    advance && hit |=> out_valid)
    else $error("accepted frame did not reach the output register");

  // A waiting result is never overwritten by a newer one.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall && in_full && hit |-> !advance)
    else $error("pending result would be overwritten");

  // A byte held in the input register stays put until the parser takes it.
  a_hold_byte: assert property (@(posedge clk) disable iff (rst)
    in_full && !advance |=> in_full && $stable(in_byte))
    else $error("held input byte lost or changed");

endmodule

`default_nettype wire

FILE: rtl/imu_afp_parser.sv
// ----------------------------------------------------------------------------
// imu_afp_parser: frame state machine, checksum and angle byte store
// Consumes one byte per step and flags a frame that passes check and id match.
// ----------------------------------------------------------------------------
`default_nettype none

module imu_afp_parser import imu_afp_pkg::*; #(
  parameter int unsigned MAX_PAYLOAD = 32
) (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  step,
  input  wire byte_t rx_byte,
  input  wire byte_t attitude_id,
  output logic       hit,
  output angles_t    angles
);

  typedef enum logic [2:0] {
    PH_SYNC1 = 3'd0,
    PH_SYNC2 = 3'd1,
    PH_ID    = 3'd2,
    PH_LEN   = 3'd3,
    PH_DATA  = 3'd4,
    PH_CHECK = 3'd5
  } phase_t;

  localparam byte_t MAX_LEN = byte_t'(MAX_PAYLOAD);

  phase_t            phase;
  byte_t             running_sum;
  byte_t             frame_id;
  logic [LEN_W-1:0]  payload_length;
  logic [LEN_W-1:0]  payload_position;
  byte_t             angle_bytes [ANGLE_BYTES];

  logic [LEN_W-1:0]  position_next;
  byte_t             sum_next;

  assign position_next = payload_position + LEN_W'(1);
  assign sum_next      = running_sum + rx_byte;

  // A frame is a hit when the byte in the checksum slot equals the sum so far and its id equals attitude_id.
  assign hit = (phase == PH_CHECK) && (running_sum == rx_byte) &&
               (frame_id == attitude_id);

  assign angles.roll  = {angle_bytes[1], angle_bytes[0]};
  assign angles.pitch = {angle_bytes[3], angle_bytes[2]};
  assign angles.yaw   = {angle_bytes[5], angle_bytes[4]};

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_SYNC1;
      running_sum      <= '0;
      frame_id         <= '0;
      payload_length   <= '0;
      payload_position <= '0;
      for (int i = 0; i < ANGLE_BYTES; i++) begin
        angle_bytes[i] <= '0;
      end
    end else if (step) begin
      unique case (phase)
        PH_SYNC2: begin
          if (rx_byte == SYNC_BYTE) begin
            running_sum <= sum_next;
            phase       <= PH_ID;
          end else begin
            phase <= PH_SYNC1;
          end
        end
        PH_ID: begin
          frame_id    <= rx_byte;
          running_sum <= sum_next;
          phase       <= PH_LEN;
        end
        PH_LEN: begin
          if (rx_byte <= MAX_LEN) begin
            payload_length   <= rx_byte[LEN_W-1:0];
            running_sum      <= sum_next;
            payload_position <= '0;
            phase            <= (rx_byte != '0) ? PH_DATA : PH_CHECK;
          end else begin
            phase <= PH_SYNC1;
          end
        end
        PH_DATA: begin
          if (payload_position < LEN_W'(ANGLE_BYTES)) begin
            angle_bytes[payload_position[ANGLE_IDX_W-1:0]] <= rx_byte;
          end
          running_sum      <= sum_next;
          payload_position <= position_next;
          if (position_next == payload_length) begin
            phase <= PH_CHECK;
          end
        end
        PH_CHECK: begin
          phase <= PH_SYNC1;
        end
        default: begin
          if (rx_byte == SYNC_BYTE) begin
            running_sum <= rx_byte;
            phase       <= PH_SYNC2;
          end else begin
            phase <= PH_SYNC1;
          end
        end
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: rtl/imu_afp_result_reg.sv
// ----------------------------------------------------------------------------
// imu_afp_result_reg: output register of the attitude frame parser
// Holds one finished angle word until the receiver takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module imu_afp_result_reg import imu_afp_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    load,
  input  wire angles_t load_data,
  input  wire logic    out_stall,
  output logic         out_valid,
  output angles_t      data
);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data <= load_data;
    end
  end

endmodule

`default_nettype wire
